// File: rtl/mendelian_error_checker_defines.svh
// assertion macros for the mendelian error checker
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef MENDELIAN_ERROR_CHECKER_DEFINES_SVH
`define MENDELIAN_ERROR_CHECKER_DEFINES_SVH

// same-cycle implication, off during reset
`define MEC_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("mendelian error checker: assertion failed");

// next-cycle implication, off during reset
`define MEC_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("mendelian error checker: assertion failed");

`endif

// File: rtl/mec_pkg.sv
// shared types, codes and the inheritance check for the mendelian error checker
// no dependencies
package mec_pkg;

    localparam int DEF_NUM_LOCI   = 1024;
    localparam int DEF_COUNT_BITS = 16;

    localparam int LOCUS_W    = 10;
    localparam int GT_W       = 2;
    localparam int LEVEL_W    = 2;
    localparam int FAM_ERR_W  = 16;
    localparam int AFF_W      = 11;
    localparam int TOTAL_W    = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // genotype codes
    localparam logic [GT_W-1:0] GT_MISSING = 2'd0;
    localparam logic [GT_W-1:0] GT_AA      = 2'd1;
    localparam logic [GT_W-1:0] GT_AB      = 2'd2;
    localparam logic [GT_W-1:0] GT_BB      = 2'd3;

    // action levels
    localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_STRIP = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_PURGE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL           = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PURGE_THRESHOLD = 1'd1;

    typedef enum logic [1:0] {
        ACT_KEEP  = 2'd0,
        ACT_STRIP = 2'd1,
        ACT_PURGE = 2'd2
    } t_action;

    typedef struct packed {
        logic [LOCUS_W-1:0] locus;
        logic [GT_W-1:0]    father_gt;
        logic [GT_W-1:0]    mother_gt;
        logic [GT_W-1:0]    child_gt;
        logic               last_of_family;
    } t_item;

    typedef struct packed {
        logic                 error_here;
        logic                 family_done;
        t_action              family_action;
        logic [FAM_ERR_W-1:0] family_errors;
        logic [AFF_W-1:0]     affected_loci;
        logic [TOTAL_W-1:0]   overall_errors;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic commit;
        logic sweep_rd;
        logic clear_wr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic item_last;
    } t_status;

    function automatic logic mendel_error(
        input logic [GT_W-1:0] f,
        input logic [GT_W-1:0] m,
        input logic [GT_W-1:0] c
    );
        logic [GT_W-1:0] p;
        logic            err;
        p   = (f == GT_MISSING) ? m : f;
        err = 1'b0;
        if (c == GT_MISSING || (f == GT_MISSING && m == GT_MISSING)) begin
            err = 1'b0;
        end else if (f == GT_MISSING || m == GT_MISSING) begin
            // single parent: only homozygous opposites clash
            err = (p == GT_AA && c == GT_BB) || (p == GT_BB && c == GT_AA);
        end else if (f == m) begin
            err = (c != f) && (f != GT_AB);
        end else if ((f == GT_AA && m == GT_BB) || (f == GT_BB && m == GT_AA)) begin
            err = (c != GT_AB);
        end else begin
            err = (c != f) && (c != m);
        end
        return err;
    endfunction

endpackage

// File: rtl/mec_stream_if.sv
// valid/ready stream channel carrying one item per handshake
// payload type given by parameter
interface mec_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mec_ctrl.sv
// controller: item sequencing, post-reset clear and end-of-family sweep
// depends on mec_pkg
module mec_ctrl #(
    parameter int NUM_LOCI = mec_pkg::DEF_NUM_LOCI,
    parameter int LOCI_AW  = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    input  mec_pkg::t_status   i_status,
    output mec_pkg::t_cmd      o_cmd,
    output logic [LOCI_AW-1:0] o_addr
);
    import mec_pkg::*;

    localparam logic [LOCI_AW-1:0] LAST_ADDR = LOCI_AW'(NUM_LOCI - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COMMIT,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

    t_state             r_state, n_state;
    logic [LOCI_AW-1:0] r_addr, n_addr;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_INIT: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    n_addr  = '0;
                    n_state = i_status.item_last ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_item_ready      = (r_state == ST_IDLE);
    assign o_cmd.take_item   = (r_state == ST_IDLE) && i_item_valid;
    assign o_cmd.commit      = (r_state == ST_COMMIT) && i_status.out_free;
    assign o_cmd.sweep_rd    = (r_state == ST_SWEEP);
    assign o_cmd.clear_wr    = (r_state == ST_INIT);
    assign o_addr            = r_addr;

endmodule

// File: rtl/mec_datapath.sv
// datapath: item register, locus memories, family counters, result register
// depends on mec_pkg; driven by mec_ctrl commands
module mec_datapath #(
    parameter int NUM_LOCI   = mec_pkg::DEF_NUM_LOCI,
    parameter int COUNT_BITS = mec_pkg::DEF_COUNT_BITS,
    parameter int LOCI_AW    = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mec_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  mec_pkg::t_item                 i_item,
    input  mec_pkg::t_cmd                  i_cmd,
    input  logic [LOCI_AW-1:0]             i_addr,
    output mec_pkg::t_status               o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mec_pkg::t_result               o_out
);
    import mec_pkg::*;

    // configuration
    logic [LEVEL_W-1:0]    r_level;
    logic [FAM_ERR_W-1:0]  r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_NONE;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEVEL:           r_level     <= i_cfg_wdata[LEVEL_W-1:0];
                REG_PURGE_THRESHOLD: r_threshold <= i_cfg_wdata[FAM_ERR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // item register
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_item;
        end
    end

    function automatic logic [LOCI_AW-1:0] locus_addr(input logic [LOCUS_W-1:0] loc);
        logic [31:0] ext;
        ext = {{(32-LOCUS_W){1'b0}}, loc};
        return ext[LOCI_AW-1:0];
    endfunction

    logic        in_range;
    logic [31:0] item_ext;
    assign item_ext = {{(32-LOCUS_W){1'b0}}, r_item.locus};
    assign in_range = (item_ext < 32'(NUM_LOCI));

    // locus memories
    logic                  r_map_mem [NUM_LOCI];
    logic [COUNT_BITS-1:0] r_cnt_mem [NUM_LOCI];
    logic                  r_map_rd;
    logic [COUNT_BITS-1:0] r_cnt_rd;

    // sweep write-back stage, registered from the read command and address
    logic                  r_wb_valid;
    logic [LOCI_AW-1:0]    r_wb_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= i_cmd.sweep_rd;
        end
        r_wb_addr <= i_addr;
    end

    logic               err;
    logic               mark;
    logic               map_re;
    logic [LOCI_AW-1:0] map_raddr;
    logic               map_we;
    logic [LOCI_AW-1:0] map_waddr;
    logic               map_wdata;
    logic               cnt_we;
    logic [LOCI_AW-1:0] cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;

    assign err  = mendel_error(r_item.father_gt, r_item.mother_gt, r_item.child_gt);
    assign mark = err && in_range && r_map_rd;

    assign map_re    = i_cmd.take_item || i_cmd.sweep_rd;
    assign map_raddr = i_cmd.sweep_rd ? i_addr : locus_addr(i_item.locus);

    always_comb begin
        map_we    = 1'b0;
        map_waddr = i_addr;
        map_wdata = 1'b1;
        cnt_we    = 1'b0;
        cnt_waddr = i_addr;
        cnt_wdata = '0;
        if (i_cmd.clear_wr) begin
            map_we = 1'b1;
            cnt_we = 1'b1;
        end else if (r_wb_valid) begin
            map_we    = 1'b1;
            map_waddr = r_wb_addr;
            cnt_waddr = r_wb_addr;
            // affected locus: bump its family count, saturating
            cnt_we    = !r_map_rd;
            cnt_wdata = (&r_cnt_rd) ? r_cnt_rd : r_cnt_rd + 1'b1;
        end else if (i_cmd.commit && mark) begin
            map_we    = 1'b1;
            map_waddr = locus_addr(r_item.locus);
            map_wdata = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            r_map_rd <= r_map_mem[map_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (i_cmd.sweep_rd) begin
            r_cnt_rd <= r_cnt_mem[i_addr];
        end
    end

    // family and overall counters
    logic [FAM_ERR_W-1:0] r_fam, n_fam;
    logic [AFF_W-1:0]     r_aff, n_aff;
    logic [TOTAL_W-1:0]   r_tot, n_tot;
    t_action              action;

    assign n_fam = (err && !(&r_fam)) ? r_fam + 1'b1 : r_fam;
    assign n_aff = (mark && !(&r_aff)) ? r_aff + 1'b1 : r_aff;
    assign n_tot = (err && !(&r_tot)) ? r_tot + 1'b1 : r_tot;

    always_comb begin
        action = ACT_KEEP;
        if (r_item.last_of_family) begin
            if (r_level == LEVEL_PURGE && n_fam > r_threshold) begin
                action = ACT_PURGE;
            end else if ((r_level == LEVEL_STRIP || r_level == LEVEL_PURGE)
                         && n_aff != '0) begin
                action = ACT_STRIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fam <= '0;
            r_aff <= '0;
            r_tot <= '0;
        end else if (i_cmd.commit) begin
            r_fam <= r_item.last_of_family ? '0 : n_fam;
            r_aff <= r_item.last_of_family ? '0 : n_aff;
            r_tot <= n_tot;
        end
    end

    // result register
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.error_here     <= err;
            r_out.family_done    <= r_item.last_of_family;
            r_out.family_action  <= action;
            r_out.family_errors  <= n_fam;
            r_out.affected_loci  <= n_aff;
            r_out.overall_errors <= n_tot;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.item_last = r_item.last_of_family;

endmodule

// File: rtl/mendelian_error_checker.sv
// Mendelian inheritance consistency checker, one family at a time.
// Input channel i_item: one (child, locus) item with father, mother and child
// genotype codes and a last-of-family flag. Output channel o_result: one result
// per item with the error flag, the family's error and affected-locus counts,
// the overall error count and, on the family's last item, the family action.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 level, 1 purge threshold); write only while the block is idle.
// One item is in flight at a time: it is accepted, then committed, and only then
// is the next accepted; the registered read of the affected-locus map sets this
// (accept state, then a read-modify-write commit state). The result register is
// loaded at the commit edge, so the result is valid in the cycle after the commit.
// After a family's last item the block sweeps every locus, bumping the
// per-locus family count of affected loci and restoring the map; no item is
// taken during the sweep or the drain state that follows it.
// Reset: synchronous, active low; afterwards a clearing pass over every locus
// runs before the first item is accepted.
// A stalled receiver holds the result register; the next item may still be
// accepted, and its commit waits until the result register is taken.
// depends on mec_pkg, mec_stream_if, mec_ctrl, mec_datapath
module mendelian_error_checker #(
    parameter int NUM_LOCI   = mec_pkg::DEF_NUM_LOCI,
    parameter int COUNT_BITS = mec_pkg::DEF_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mec_stream_if.sink                     i_item,
    mec_stream_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mec_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mec_pkg::*;

    localparam int LOCI_AW = (NUM_LOCI > 1) ? $clog2(NUM_LOCI) : 1;

    t_cmd               cmd;
    t_status            status;
    logic [LOCI_AW-1:0] addr;
    logic               item_ready;

    mec_ctrl #(
        .NUM_LOCI (NUM_LOCI),
        .LOCI_AW  (LOCI_AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_addr       (addr)
    );

    mec_datapath #(
        .NUM_LOCI   (NUM_LOCI),
        .COUNT_BITS (COUNT_BITS),
        .LOCI_AW    (LOCI_AW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item.payload),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .o_status    (status),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_out       (o_result.payload)
    );

    assign i_item.ready = item_ready;

`include "mendelian_error_checker_defines.svh"

    `MEC_ASSERT_IMP(a_action_only_when_done, o_result.valid && !o_result.payload.family_done, o_result.payload.family_action == ACT_KEEP)
    `MEC_ASSERT_NEXT(a_one_item_in_flight, i_item.valid && i_item.ready, !i_item.ready)
    `MEC_ASSERT_IMP(a_affected_within_errors, o_result.valid, 16'(o_result.payload.affected_loci) <= o_result.payload.family_errors)

endmodule
